FILE: sv/huffman_tree_table_codec_core_assert.svh
// Assertion macros for the checker of the codec core.
`ifndef HUFFMAN_TREE_TABLE_CODEC_CORE_ASSERT_SVH
`define HUFFMAN_TREE_TABLE_CODEC_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define HTC_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define HTC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: sv/htc_pkg.sv
// Shared types and constants of the Huffman tree table codec.
package htc_pkg;

	localparam int NUM_SYMBOLS     = 256;
	localparam int NUM_NODES       = 511;
	localparam int MAX_CODE_LENGTH = 64;

	localparam int NODE_W = 9;
	localparam int SYM_W  = 8;
	localparam int LEN_W  = $clog2(MAX_CODE_LENGTH + 1);

	// command queue between front and back
	localparam int CQ_DEPTH = 4;
	localparam int CQ_AW    = $clog2(CQ_DEPTH);

	localparam logic [NODE_W-1:0] ROOT_IDX  = NODE_W'(NUM_NODES - 1);
	localparam logic [NODE_W-1:0] NODES_LIM = NODE_W'(NUM_NODES);
	localparam logic [NODE_W-1:0] SYMS_LIM  = NODE_W'(NUM_SYMBOLS);
	localparam logic [LEN_W-1:0]  LEN_MAX   = LEN_W'(MAX_CODE_LENGTH);

	// input action codes
	typedef enum logic [1:0] {
		ACT_WRITE  = 2'd0,
		ACT_ENCODE = 2'd1,
		ACT_DECODE = 2'd2
	} action_t;

	// result kinds
	typedef enum logic [1:0] {
		KIND_BIT = 2'd0,
		KIND_SYM = 2'd1,
		KIND_ERR = 2'd2
	} kind_t;

	// classified commands handed from front to back
	typedef enum logic [1:0] {
		CMD_WRITE  = 2'd0,
		CMD_ENCODE = 2'd1,
		CMD_DECODE = 2'd2,
		CMD_ERROR  = 2'd3
	} cmd_op_t;

	// one node table entry
	typedef struct packed {
		logic [NODE_W-1:0] left;
		logic [NODE_W-1:0] right;
		logic [NODE_W-1:0] parent;
		logic              branch;
	} node_t;

	typedef struct packed {
		cmd_op_t           op;
		logic [NODE_W-1:0] addr;
		node_t             node;
		logic              coded;
	} cmd_t;

	typedef struct packed {
		kind_t            kind;
		logic             bit_out;
		logic [SYM_W-1:0] symbol_out;
		logic             last;
	} res_t;

endpackage

FILE: sv/htc_front.sv
// Input side: classifies transactions and queues them as commands.
module htc_front import htc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  logic [1:0]        action,
	input  logic [NODE_W-1:0] node_index,
	input  logic [NODE_W-1:0] left_child,
	input  logic [NODE_W-1:0] right_child,
	input  logic [NODE_W-1:0] parent_index,
	input  logic              branch_bit,
	input  logic [SYM_W-1:0]  symbol_in,
	input  logic              coded_bit,
	input  logic              cmd_pop,
	output logic              cmd_valid,
	output cmd_t              cmd
);

	cmd_t             q_q [CQ_DEPTH];
	logic [CQ_AW-1:0] wr_q, rd_q;
	logic [CQ_AW:0]   cnt_q;
	cmd_t             cls;
	logic             keep;
	logic             enq, deq;

	// classify: drop unknown actions and out-of-range writes
	always_comb begin
		cls.op          = CMD_WRITE;
		cls.addr        = node_index;
		cls.node.left   = left_child;
		cls.node.right  = right_child;
		cls.node.parent = parent_index;
		cls.node.branch = branch_bit;
		cls.coded       = coded_bit;
		keep            = 1'b0;
		unique case (action)
			ACT_WRITE: begin
				cls.op = CMD_WRITE;
				keep   = (node_index < NODES_LIM);
			end
			ACT_ENCODE: begin
				cls.addr = NODE_W'(symbol_in);
				cls.op   = (NODE_W'(symbol_in) < SYMS_LIM) ? CMD_ENCODE : CMD_ERROR;
				keep     = 1'b1;
			end
			ACT_DECODE: begin
				cls.op = CMD_DECODE;
				keep   = 1'b1;
			end
			default: keep = 1'b0;
		endcase
	end

	assign full      = (cnt_q == (CQ_AW+1)'(CQ_DEPTH));
	assign cmd_valid = (cnt_q != '0);
	assign cmd       = q_q[rd_q];
	assign enq       = push && !full && keep;
	assign deq       = cmd_pop && cmd_valid;

	// queue storage
	always_ff @(posedge clk) begin
		if (enq) begin
			q_q[wr_q] <= cls;
		end
	end

	// queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (enq) begin
				wr_q <= wr_q + 1'b1;
			end
			if (deq) begin
				rd_q <= rd_q + 1'b1;
			end
			cnt_q <= cnt_q + (CQ_AW+1)'(enq) - (CQ_AW+1)'(deq);
		end
	end

endmodule

FILE: sv/htc_back.sv
// Execution side: node table, tree walks, decode pointer and result register.
module htc_back import htc_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  cmd_t    cmd,
	input  logic    cmd_valid,
	output logic    cmd_pop,
	input  logic    pop,
	output logic    empty,
	output res_t    res
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WALK,
		ST_EMIT,
		ST_DSTEP,
		ST_SEND
	} state_t;

	state_t            state_q;
	node_t             mem [NUM_NODES];
	node_t             rdata_s1;
	logic [NODE_W-1:0] rd_addr;
	logic              mem_we;
	logic [NODE_W-1:0] ptr_q;
	logic [MAX_CODE_LENGTH-1:0] path_q;
	logic [LEN_W-1:0]  len_q;
	logic [LEN_W-1:0]  len_nx;
	logic              dbit_q;
	kind_t             one_kind_q;
	logic [SYM_W-1:0]  one_sym_q;
	logic              out_valid_q;
	res_t              out_q;
	logic              out_free;
	logic              out_load;
	logic [NODE_W-1:0] child;

	assign out_free = !out_valid_q || pop;
	assign out_load = ((state_q == ST_EMIT) || (state_q == ST_SEND)) && out_free;
	assign empty    = !out_valid_q;
	assign res      = out_q;
	assign cmd_pop  = (state_q == ST_IDLE) && cmd_valid;
	assign mem_we   = cmd_pop && (cmd.op == CMD_WRITE);
	assign len_nx   = len_q + 1'b1;
	assign child    = dbit_q ? rdata_s1.right : rdata_s1.left;

	// read address: start of a walk, decode pointer, or the parent just read
	always_comb begin
		rd_addr = ptr_q;
		if (state_q == ST_WALK) begin
			rd_addr = rdata_s1.parent;
		end else if (cmd_pop && cmd.op == CMD_ENCODE) begin
			rd_addr = cmd.addr;
		end
	end

	// node table, registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[cmd.addr] <= cmd.node;
		end
		rdata_s1 <= mem[rd_addr];
	end

	// sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ptr_q       <= ROOT_IDX;
			path_q      <= '0;
			len_q       <= '0;
			dbit_q      <= 1'b0;
			one_kind_q  <= KIND_ERR;
			one_sym_q   <= '0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			// result slot: loaded by emit or send, freed by a pop
			out_valid_q <= out_load || (out_valid_q && !pop);
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_valid) begin
						case (cmd.op)
							CMD_ENCODE: begin
								len_q   <= '0;
								path_q  <= '0;
								state_q <= ST_WALK;
							end
							CMD_DECODE: begin
								dbit_q  <= cmd.coded;
								state_q <= ST_DSTEP;
							end
							CMD_ERROR: begin
								one_kind_q <= KIND_ERR;
								one_sym_q  <= '0;
								state_q    <= ST_SEND;
							end
							default: state_q <= ST_IDLE;
						endcase
					end
				end
				// one tree level per cycle, leaf toward root
				ST_WALK: begin
					path_q <= {path_q[MAX_CODE_LENGTH-2:0], rdata_s1.branch};
					len_q  <= len_nx;
					if (rdata_s1.parent >= NODES_LIM) begin
						one_kind_q <= KIND_ERR;
						one_sym_q  <= '0;
						state_q    <= ST_SEND;
					end else if (rdata_s1.parent == ROOT_IDX) begin
						state_q <= ST_EMIT;
					end else if (len_nx == LEN_MAX) begin
						one_kind_q <= KIND_ERR;
						one_sym_q  <= '0;
						state_q    <= ST_SEND;
					end
				end
				// bit nearest the root sits at bit 0
				ST_EMIT: begin
					if (out_free) begin
						out_q.kind       <= KIND_BIT;
						out_q.bit_out    <= path_q[0];
						out_q.symbol_out <= '0;
						out_q.last       <= (len_q == LEN_W'(1));
						path_q           <= path_q >> 1;
						len_q            <= len_q - 1'b1;
						if (len_q == LEN_W'(1)) begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_DSTEP: begin
					if (child >= NODES_LIM) begin
						ptr_q   <= ROOT_IDX;
						state_q <= ST_IDLE;
					end else if (child < SYMS_LIM) begin
						ptr_q      <= ROOT_IDX;
						one_kind_q <= KIND_SYM;
						one_sym_q  <= child[SYM_W-1:0];
						state_q    <= ST_SEND;
					end else begin
						ptr_q   <= child;
						state_q <= ST_IDLE;
					end
				end
				ST_SEND: begin
					if (out_free) begin
						out_q.kind       <= one_kind_q;
						out_q.bit_out    <= 1'b0;
						out_q.symbol_out <= one_sym_q;
						out_q.last       <= 1'b1;
						state_q          <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

FILE: sv/huffman_tree_table_codec_core.sv
// An accepted transaction is registered in the command queue; the back end pops it when idle.
// Decode step: reads the node at the decode pointer, then moves the pointer or sends a symbol.
// Encode of an L-bit code: a walk of L levels (one node table read per level), then one result per
// cycle while the result register is free; a write goes into the node table when popped.
// The back end finishes each command before it takes the next, with one node table read port.
// Reset: queues empty, decode pointer at the root; node table is undefined until written.
module huffman_tree_table_codec_core import htc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  logic [1:0]        action,
	input  logic [NODE_W-1:0] node_index,
	input  logic [NODE_W-1:0] left_child,
	input  logic [NODE_W-1:0] right_child,
	input  logic [NODE_W-1:0] parent_index,
	input  logic              branch_bit,
	input  logic [SYM_W-1:0]  symbol_in,
	input  logic              coded_bit,
	output logic              empty,
	input  logic              pop,
	output logic [1:0]        kind,
	output logic              bit_out,
	output logic [SYM_W-1:0]  symbol_out,
	output logic              last
);

	cmd_t    cmd;
	logic    cmd_valid;
	logic    cmd_pop;
	res_t    res;

	htc_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.action       (action),
		.node_index   (node_index),
		.left_child   (left_child),
		.right_child  (right_child),
		.parent_index (parent_index),
		.branch_bit   (branch_bit),
		.symbol_in    (symbol_in),
		.coded_bit    (coded_bit),
		.cmd_pop      (cmd_pop),
		.cmd_valid    (cmd_valid),
		.cmd          (cmd)
	);

	htc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.cmd_valid (cmd_valid),
		.cmd_pop   (cmd_pop),
		.pop       (pop),
		.empty     (empty),
		.res       (res)
	);

	// result transaction fields
	assign kind       = res.kind;
	assign bit_out    = res.bit_out;
	assign symbol_out = res.symbol_out;
	assign last       = res.last;

endmodule

FILE: sv/htc_checker.sv
// Port-level checker for the codec core, bound to the top level.
`include "huffman_tree_table_codec_core_assert.svh"

module htc_checker import htc_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             empty,
	input logic             pop,
	input logic [1:0]       kind,
	input logic             bit_out,
	input logic [SYM_W-1:0] symbol_out,
	input logic             last
);

	// a symbol or error result always closes its transaction
	`HTC_ASSERT_IMPL(a_single_last, !empty && (kind == KIND_SYM || kind == KIND_ERR), last, "symbol or error result without last")
	// an error result carries no bit and no symbol
	`HTC_ASSERT_IMPL(a_err_clean, !empty && kind == KIND_ERR, !bit_out && symbol_out == '0, "error result with payload")
	// encoded bits carry no symbol, and no undefined kind appears
	`HTC_ASSERT_IMPL(a_bit_clean, !empty, (kind == KIND_BIT || kind == KIND_SYM || kind == KIND_ERR) && (kind != KIND_BIT || symbol_out == '0), "bad result kind or payload")
	// a waiting result holds until taken
	`HTC_ASSERT_NEXT(a_hold, !empty && !pop, !empty && $stable(kind) && $stable(bit_out) && $stable(symbol_out) && $stable(last), "waiting result changed")

endmodule

bind huffman_tree_table_codec_core htc_checker u_htc_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.empty      (empty),
	.pop        (pop),
	.kind       (kind),
	.bit_out    (bit_out),
	.symbol_out (symbol_out),
	.last       (last)
);
